### sv/lsu_pkg.sv
package lsu_pkg;

    localparam logic [1:0] MODE_MINMOD   = 2'd0;
    localparam logic [1:0] MODE_MC       = 2'd1;
    localparam logic [1:0] MODE_SUPERBEE = 2'd2;

    localparam int unsigned NUM_LANES = 3;
    localparam int unsigned LANE_L    = 0;
    localparam int unsigned LANE_R    = 1;
    localparam int unsigned LANE_C    = 2;

    localparam logic ADDR_MODE = 1'b0;

endpackage

### sv/lsu_cell.sv
module lsu_cell #(
    parameter int DW = 32,
    parameter int W  = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_bad,
    input  logic [2:0][DW-1:0]  i_rem,
    input  logic [2:0][W-1:0]   i_nq,
    input  logic [2:0][DW-1:0]  i_den,
    input  logic [2:0]          i_neg,
    output logic                o_valid,
    output logic                o_bad,
    output logic [2:0][DW-1:0]  o_rem,
    output logic [2:0][W-1:0]   o_nq,
    output logic [2:0][DW-1:0]  o_den,
    output logic [2:0]          o_neg
);
    import lsu_pkg::*;

    logic                r_valid;
    logic                r_bad;
    logic [2:0][DW-1:0]  r_rem, n_rem;
    logic [2:0][W-1:0]   r_nq, n_nq;
    logic [2:0][DW-1:0]  r_den;
    logic [2:0]          r_neg;

    // one restoring division step per lane
    always_comb begin
        logic [DW:0] t;
        for (int k = 0; k < NUM_LANES; k++) begin
            t = {i_rem[k], i_nq[k][W-1]};
            if (t >= {1'b0, i_den[k]}) begin
                t = t - {1'b0, i_den[k]};
                n_nq[k] = {i_nq[k][W-2:0], 1'b1};
            end else begin
                n_nq[k] = {i_nq[k][W-2:0], 1'b0};
            end
            n_rem[k] = t[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bad <= i_bad;
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_den <= i_den;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_bad   = r_bad;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_den   = r_den;
    assign o_neg   = r_neg;

endmodule

### sv/lsu_limiter.sv
module lsu_limiter #(
    parameter int DW = 32,
    parameter int W  = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_bad,
    input  logic [2:0][W-1:0]   i_q,
    input  logic [2:0]          i_neg,
    input  logic [1:0]          i_mode,
    output logic                o_valid,
    output logic                o_bad,
    output logic [DW-1:0]       o_slope
);
    import lsu_pkg::*;

    typedef logic signed [DW-1:0] t_sval;

    logic                r_v1, r_v2;
    logic                r_bad1, r_bad2;
    t_sval [2:0]         r_s, n_s;
    t_sval               r_slope, n_slope;

    function automatic t_sval dbl(input t_sval x);
        if (x[DW-1] != x[DW-2]) begin
            dbl = x[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            dbl = {x[DW-2:0], 1'b0};
        end
    endfunction

    function automatic t_sval mm2(input t_sval a, input t_sval b);
        if (a > 0 && b > 0) begin
            mm2 = (a < b) ? a : b;
        end else if (a < 0 && b < 0) begin
            mm2 = (a > b) ? a : b;
        end else begin
            mm2 = '0;
        end
    endfunction

    function automatic t_sval mx2(input t_sval a, input t_sval b);
        if (a > 0 && b > 0) begin
            mx2 = (a > b) ? a : b;
        end else if (a < 0 && b < 0) begin
            mx2 = (a < b) ? a : b;
        end else begin
            mx2 = '0;
        end
    endfunction

    // saturate quotients to the signed word range
    always_comb begin
        logic big;
        for (int k = 0; k < NUM_LANES; k++) begin
            big = |i_q[k][W-1:DW-1];
            if (i_neg[k]) begin
                n_s[k] = big ? {1'b1, {(DW-1){1'b0}}} : t_sval'(-i_q[k][DW-1:0]);
            end else begin
                n_s[k] = big ? {1'b0, {(DW-1){1'b1}}} : t_sval'(i_q[k][DW-1:0]);
            end
        end
    end

    always_comb begin
        t_sval sl, sr, sc;
        sl = r_s[LANE_L];
        sr = r_s[LANE_R];
        sc = r_s[LANE_C];
        unique case (i_mode)
            MODE_MC:       n_slope = mm2(mm2(sc, dbl(sr)), dbl(sl));
            MODE_SUPERBEE: n_slope = mx2(mm2(sr, dbl(sl)), mm2(dbl(sr), sl));
            default:       n_slope = mm2(sl, sr);
        endcase
        if (r_bad1) begin
            n_slope = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s     <= n_s;
            r_bad1  <= i_bad;
            r_slope <= n_slope;
            r_bad2  <= r_bad1;
        end
    end

    assign o_valid = r_v2;
    assign o_bad   = r_bad2;
    assign o_slope = r_slope;

endmodule

### sv/limited_slope_unit.sv
// channel   | direction | handshake               | payload
// s_axis    | in        | tvalid / tready         | tdata: six cell fields
// m_axis    | out       | tvalid / tready         | tdata: slope, tuser: bad_spacing
// apb       | in        | psel, penable, pwrite   | limiter_mode at addresses 0 to 3
//
// one word accepted per cycle while m_axis is not stalled, results leave in order
// through the chain of division cells, one quotient bit per cell, then the limiter
// synchronous active-low reset clears valid bits and limiter_mode
// a stall on m_axis freezes the whole chain and drops s_axis_tready
module limited_slope_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // value_left, value_mid, value_right, pos_left, pos_mid, pos_right
    input  logic [((6*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // slope
    output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // bad_spacing
    output logic [0:0]                    m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lsu_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int W   = DATA_WIDTH + FRAC_BITS;
    localparam int OTW = ((DATA_WIDTH + 7) / 8) * 8;

    logic [1:0] r_mode;
    logic       en;

    logic [W:0]                 c_valid;
    logic [W:0]                 c_bad;
    logic [W:0][2:0][DW-1:0]    c_rem;
    logic [W:0][2:0][W-1:0]     c_nq;
    logic [W:0][2:0][DW-1:0]    c_den;
    logic [W:0][2:0]            c_neg;

    logic [DW:0]       vl, vr, vc, xl, xr, xc;

    logic              out_bad;
    logic [DW-1:0]     out_slope;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MINMOD;
        end else if (psel && penable && pwrite && paddr[2] == ADDR_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end
    assign prdata = (paddr[2] == ADDR_MODE) ? {30'd0, r_mode} : 32'd0;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    function automatic logic [DW:0] dmag(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] d;
        d = {a[DW-1], a} - {b[DW-1], b};
        dmag = d[DW] ? {1'b1, DW'(-d)} : {1'b0, d[DW-1:0]};
    endfunction

    // front: exact differences as sign and magnitude
    assign vl = dmag(s_axis_tdata[DW +: DW], s_axis_tdata[0 +: DW]);
    assign vr = dmag(s_axis_tdata[2*DW +: DW], s_axis_tdata[DW +: DW]);
    assign vc = dmag(s_axis_tdata[2*DW +: DW], s_axis_tdata[0 +: DW]);
    assign xl = dmag(s_axis_tdata[4*DW +: DW], s_axis_tdata[3*DW +: DW]);
    assign xr = dmag(s_axis_tdata[5*DW +: DW], s_axis_tdata[4*DW +: DW]);
    assign xc = dmag(s_axis_tdata[5*DW +: DW], s_axis_tdata[3*DW +: DW]);

    assign c_valid[0] = s_axis_tvalid;
    assign c_bad[0]   = (xl[DW-1:0] == '0) || (xr[DW-1:0] == '0)
                        || (r_mode == MODE_MC && xc[DW-1:0] == '0);
    assign c_rem[0]   = '0;
    assign c_nq[0][LANE_L]  = {vl[DW-1:0], {FRAC_BITS{1'b0}}};
    assign c_nq[0][LANE_R]  = {vr[DW-1:0], {FRAC_BITS{1'b0}}};
    assign c_nq[0][LANE_C]  = {vc[DW-1:0], {FRAC_BITS{1'b0}}};
    assign c_den[0][LANE_L] = xl[DW-1:0];
    assign c_den[0][LANE_R] = xr[DW-1:0];
    assign c_den[0][LANE_C] = xc[DW-1:0];
    assign c_neg[0][LANE_L] = vl[DW] ^ xl[DW];
    assign c_neg[0][LANE_R] = vr[DW] ^ xr[DW];
    assign c_neg[0][LANE_C] = vc[DW] ^ xc[DW];

    for (genvar g = 0; g < W; g++) begin : g_cell
        lsu_cell #(.DW(DW), .W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_bad   (c_bad[g]),
            .i_rem   (c_rem[g]),
            .i_nq    (c_nq[g]),
            .i_den   (c_den[g]),
            .i_neg   (c_neg[g]),
            .o_valid (c_valid[g+1]),
            .o_bad   (c_bad[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_nq    (c_nq[g+1]),
            .o_den   (c_den[g+1]),
            .o_neg   (c_neg[g+1])
        );
    end

    lsu_limiter #(.DW(DW), .W(W)) u_limiter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid[W]),
        .i_bad   (c_bad[W]),
        .i_q     (c_nq[W]),
        .i_neg   (c_neg[W]),
        .i_mode  (r_mode),
        .o_valid (m_axis_tvalid),
        .o_bad   (out_bad),
        .o_slope (out_slope)
    );

    assign m_axis_tdata = OTW'(out_slope);
    assign m_axis_tuser = out_bad;

    a_ready_follows_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> out_slope == '0)
        else $error("bad spacing with nonzero slope");

    a_chain_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(c_valid[W:1]))
        else $error("division chain moved during stall");

endmodule

### bench/slope_checker.sv
`timescale 1ns / 100ps

module slope_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    input  logic [1:0]   limiter_mode,
    output int           o_errors,
    output int           o_pending
);
    import lsu_pkg::*;

    typedef struct packed {
        logic [31:0] slope;
        logic        bad_spacing;
    } t_slope_result;

    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    t_slope_result expected_slopes[$];

    // exact quotient scaled by 2^16, truncated toward zero, saturated
    function automatic longint quotient_q16(longint num, longint den);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = 128'(num) <<< 16;
        q = n / 128'(den);
        if (q > S_MAX) return S_MAX;
        if (q < S_MIN) return S_MIN;
        return longint'(q);
    endfunction

    function automatic longint twice(longint x);
        if (2 * x > S_MAX) return S_MAX;
        if (2 * x < S_MIN) return S_MIN;
        return 2 * x;
    endfunction

    function automatic longint min_mod(longint a, longint b);
        if (a > 0 && b > 0) return (a < b) ? a : b;
        if (a < 0 && b < 0) return (a > b) ? a : b;
        return 0;
    endfunction

    function automatic longint max_mod(longint a, longint b);
        if (a > 0 && b > 0) return (a > b) ? a : b;
        if (a < 0 && b < 0) return (a < b) ? a : b;
        return 0;
    endfunction

    function automatic t_slope_result limit_slope(logic [191:0] d, logic [1:0] mode);
        longint vl, vm, vr, xl, xm, xr, sl, sr, sc, res;
        t_slope_result r;
        vl = longint'($signed(d[31:0]));
        vm = longint'($signed(d[63:32]));
        vr = longint'($signed(d[95:64]));
        xl = longint'($signed(d[127:96]));
        xm = longint'($signed(d[159:128]));
        xr = longint'($signed(d[191:160]));
        res = 0;
        r.bad_spacing = (xm == xl) || (xr == xm) || (mode == MODE_MC && xr == xl);
        if (!r.bad_spacing) begin
            sl = quotient_q16(vm - vl, xm - xl);
            sr = quotient_q16(vr - vm, xr - xm);
            if (mode == MODE_MC) begin
                sc = quotient_q16(vr - vl, xr - xl);
                res = min_mod(min_mod(sc, twice(sr)), twice(sl));
            end else if (mode == MODE_SUPERBEE) begin
                res = max_mod(min_mod(sr, twice(sl)), min_mod(twice(sr), sl));
            end else begin
                res = min_mod(sl, sr);
            end
        end
        r.slope = res[31:0];
        return r;
    endfunction

    assign o_pending = expected_slopes.size();

    always @(posedge i_clk) begin
        t_slope_result e;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_slopes.size() == 0) begin
                    $error("unexpected word slope=%h", m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_slopes.pop_front();
                    if (e.slope !== m_axis_tdata || e.bad_spacing !== m_axis_tuser[0]) begin
                        if (e.slope !== m_axis_tdata)
                            $error("slope expected %h actual %h", e.slope, m_axis_tdata);
                        if (e.bad_spacing !== m_axis_tuser[0])
                            $error("bad_spacing expected %b actual %b",
                                   e.bad_spacing, m_axis_tuser[0]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_slopes.push_back(limit_slope(s_axis_tdata, limiter_mode));
        end
    end

endmodule

### bench/tb_limited_slope_unit.sv
`timescale 1ns / 100ps

module tb_limited_slope_unit;
    import lsu_pkg::*;

    localparam int LATENCY = 32 + 16 + 2;
    localparam int CYCLE_LIMIT = 200000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic [1:0]   mode_shadow = MODE_MINMOD;
    int           errors;
    int           pending;
    int           cycles = 0;
    int           stall_phase = 0;
    int           stall_period = 7;

    always #10 i_clk = ~i_clk;

    limited_slope_unit uut (.*);

    slope_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .limiter_mode(mode_shadow), .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern, changes rhythm now and then
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_limited_slope_unit: errors");
            $finish;
        end
        stall_phase <= (stall_phase + 1) % stall_period;
        if (stall_phase == 0 && $urandom_range(0, 9) == 0)
            stall_period <= $urandom_range(1, 13);
        m_axis_tready <= (stall_period < 3) ? 1'b1 : (stall_phase < stall_period - 2);
    end

    task automatic write_mode(input logic [1:0] m);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {30'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mode_shadow <= m;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [191:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_fffc + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [191:0] rand_cell();
        logic [31:0] xl, xm, xr;
        logic [31:0] f [6];
        foreach (f[i]) f[i] = rand_field();
        if ($urandom_range(0, 3) != 0) begin
            // well-spaced ascending grid, values near each other
            xm = $urandom;
            xl = xm - $urandom_range(1, 32'h0004_0000);
            xr = xm + $urandom_range(1, 32'h0004_0000);
            f[3] = xl; f[4] = xm; f[5] = xr;
            f[1] = $urandom;
            f[0] = f[1] + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
            f[2] = f[1] + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        end
        if ($urandom_range(0, 19) == 0) f[4] = f[3];
        if ($urandom_range(0, 19) == 0) f[5] = f[4];
        if ($urandom_range(0, 19) == 0) f[5] = f[3];
        return {f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    task automatic directed();
        logic [31:0] one, mx, mn;
        one = 32'h0001_0000; mx = 32'h7fff_ffff; mn = 32'h8000_0000;
        send_word({3 * one, 2 * one, one, 3 * one, 2 * one, one});
        send_word({one, 2 * one, 5 * one, 3 * one, 2 * one, one});
        send_word({mx, 32'd0, mn, 32'd1, 32'd0, mx});
        send_word({mx, 32'd1, mn, mx, 32'd0, mn});
        send_word({mn, mx, mn, mx, 32'd0, mn});
        send_word({mx, mx, mx, 32'd2, 32'd2, 32'd1});
        send_word({mx, 32'd1, mx, 32'd2, 32'd1, 32'd1});
        send_word({mx, 32'd3, 32'd1, 32'd2, 32'd1, 32'd0});
        send_word({32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0});
        send_word({32'hffff_ffff, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
        send_word({3 * one, 2 * one, 3 * one, 4 * one, one, 32'd0});
        send_word({one, 32'd0, one, 32'd5, 32'd3, 32'd0});
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int sent, burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int m = 0; m < 4; m++) begin
            write_mode(m[1:0]);
            directed();
            drain();
        end
        sent = 0;
        while (sent < 900) begin
            if (sent % 150 == 0) begin
                drain();
                write_mode(2'($urandom_range(0, 3)));
            end
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++) begin
                send_word(rand_cell());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        drain();
        if (errors == 0)
            $display("tb_limited_slope_unit: clean");
        else
            $display("tb_limited_slope_unit: errors");
        $finish;
    end

endmodule
